// File: hdl/csres_pkg.sv
// Package for the cubic stereo resampler: widths, limits, register indexes
// and the command and status types between the controller and the datapath.
// No dependencies.
`default_nettype none
package csres_pkg;
	localparam int MAX_BLOCK_FRAMES   = 1048576;
	localparam int MAX_UPSAMPLE_RATIO = 16;
	localparam int RATE_W             = 19;
	localparam int SAMPLE_W           = 16;
	localparam int RESULT_LIMIT       = 64;
	localparam int CNT_W              = 7;
	localparam int T_W                = 16;
	localparam int DIV_W              = 20;
	localparam int IP_STEPS           = 6;
	localparam int STEP_W             = 5;
	localparam logic [RATE_W-1:0] RESET_RATE = 19'd48000;

	typedef enum logic {
		REG_INPUT_RATE  = 1'b0,
		REG_OUTPUT_RATE = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_PASS,
		OP_DIV_T_INIT,
		OP_DIV_STEP,
		OP_INTERP,
		OP_COMMIT,
		OP_EMIT,
		OP_END
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [STEP_W-1:0] step;
	} ctl_t;

	typedef struct packed {
		logic eq_rates;
		logic more;
		logic cnt_full;
		logic out_busy;
	} sts_t;
endpackage
`default_nettype wire

// File: hdl/csres_ctrl.sv
// Controller state machine of the cubic stereo resampler.
// Sequences acceptance, pass-through, division steps, interpolation steps and emission.
// Depends on csres_pkg.
`default_nettype none
module csres_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire csres_pkg::sts_t sts,
	output csres_pkg::ctl_t     ctl
);
	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_PASS   = 8'b0000_0010,
		S_CHECK  = 8'b0000_0100,
		S_TDIV   = 8'b0000_1000,
		S_INTERP = 8'b0001_0000,
		S_PDIV   = 8'b0010_0000,
		S_COMMIT = 8'b0100_0000,
		S_EMIT   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic [csres_pkg::STEP_W-1:0] step_q, step_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		ctl.op   = csres_pkg::OP_NONE;
		ctl.step = step_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.op  = csres_pkg::OP_ACCEPT;
					state_d = S_PASS;
				end
			end
			S_PASS: begin
				if (!sts.eq_rates) begin
					state_d = S_CHECK;
				end else if (!sts.out_busy) begin
					ctl.op  = csres_pkg::OP_PASS;
					state_d = S_IDLE;
				end
			end
			S_CHECK: begin
				step_d = '0;
				if (sts.more && !sts.cnt_full) begin
					ctl.op  = csres_pkg::OP_DIV_T_INIT;
					state_d = S_TDIV;
				end else begin
					ctl.op  = csres_pkg::OP_END;
					state_d = S_IDLE;
				end
			end
			S_TDIV: begin
				ctl.op = csres_pkg::OP_DIV_STEP;
				if (step_q == csres_pkg::STEP_W'(csres_pkg::T_W - 1)) begin
					step_d  = '0;
					state_d = S_INTERP;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			S_INTERP: begin
				ctl.op = csres_pkg::OP_INTERP;
				if (step_q == csres_pkg::STEP_W'(csres_pkg::IP_STEPS - 1)) begin
					step_d  = '0;
					state_d = S_PDIV;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			S_PDIV: begin
				ctl.op = csres_pkg::OP_DIV_STEP;
				if (step_q == csres_pkg::STEP_W'(csres_pkg::DIV_W - 1)) begin
					step_d  = '0;
					state_d = S_COMMIT;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			S_COMMIT: begin
				ctl.op  = csres_pkg::OP_COMMIT;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (!sts.out_busy) begin
					ctl.op  = csres_pkg::OP_EMIT;
					state_d = S_CHECK;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end
endmodule
`default_nettype wire

// File: hdl/csres_datapath.sv
// Datapath of the cubic stereo resampler: rate registers, frame window,
// position counters, shared restoring divider, Catmull-Rom lanes and output word.
// Depends on csres_pkg.
`default_nettype none
module csres_datapath #(
	parameter int MAX_BLOCK_FRAMES   = csres_pkg::MAX_BLOCK_FRAMES,
	parameter int MAX_UPSAMPLE_RATIO = csres_pkg::MAX_UPSAMPLE_RATIO
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [0:0]                          cfg_index,
	input  wire logic [csres_pkg::RATE_W-1:0]        cfg_data,
	input  wire logic signed [csres_pkg::SAMPLE_W-1:0] left_in,
	input  wire logic signed [csres_pkg::SAMPLE_W-1:0] right_in,
	input  wire logic                                block_end,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [csres_pkg::SAMPLE_W-1:0]    left_out,
	output logic signed [csres_pkg::SAMPLE_W-1:0]    right_out,
	output logic                                     run_last,
	input  wire csres_pkg::ctl_t                     ctl,
	output csres_pkg::sts_t                          sts
);
	localparam int RW  = csres_pkg::RATE_W;
	localparam int DW  = csres_pkg::DIV_W;
	localparam int FW  = $clog2(MAX_BLOCK_FRAMES + 1);
	localparam int IW  = ((FW > DW) ? FW : DW) + 2;
	localparam int UW  = $clog2(MAX_UPSAMPLE_RATIO + 1);
	localparam int CW  = RW + UW;

	logic [RW-1:0] in_rate_q, out_rate_q;
	logic signed [15:0] win_q [2][4];
	logic [FW-1:0] frames_q;
	logic [IW-1:0] idx_q;
	logic [RW-1:0] rem_q;
	logic          last_q;
	logic [csres_pkg::CNT_W-1:0] cnt_q;
	logic [DW-1:0] div_r_q, div_a_q, div_q_q;
	logic [csres_pkg::T_W-1:0] t_q;
	logic signed [19:0] a_q [2];
	logic signed [20:0] b_q [2];
	logic signed [17:0] c_q [2];
	logic signed [15:0] p1_q [2];
	logic signed [23:0] h_q [2];
	logic signed [41:0] prod_q [2];
	logic          out_valid_q, run_last_q;
	logic signed [15:0] left_q, right_q;

	logic [RW-1:0] ri, ro_raw, ro;
	logic [CW-1:0] cap;
	logic [FW-1:0] fr_new, n_w;
	logic [IW-1:0] n_x, idx_p2;
	logic [1:0]    d_w;
	logic [DW-1:0] r_sh, r_nx;
	logic          ge;
	logic signed [17:0] t_s;
	logic signed [15:0] res_w [2];

	assign ri     = (in_rate_q == '0) ? RW'(1) : in_rate_q;
	assign ro_raw = (out_rate_q == '0) ? RW'(1) : out_rate_q;
	assign cap    = CW'(ri) * CW'(MAX_UPSAMPLE_RATIO);
	assign ro     = (CW'(ro_raw) > cap) ? cap[RW-1:0] : ro_raw;

	assign fr_new = frames_q + 1'b1;
	assign n_w    = frames_q - 1'b1;
	assign n_x    = IW'(n_w);
	assign idx_p2 = idx_q + IW'(2);
	assign d_w    = (idx_p2 > n_x) ? 2'(idx_p2 - n_x) : 2'd0;

	assign r_sh = {div_r_q[DW-2:0], div_a_q[DW-1]};
	assign ge   = (r_sh >= DW'(ro));
	assign r_nx = ge ? (r_sh - DW'(ro)) : r_sh;
	assign t_s  = $signed({2'b00, t_q});

	assign sts.eq_rates = (ri == ro);
	assign sts.more     = last_q ? (idx_q <= n_x) : (idx_p2 <= n_x);
	assign sts.cnt_full = (cnt_q == csres_pkg::CNT_W'(csres_pkg::RESULT_LIMIT));
	assign sts.out_busy = out_valid_q && !out_ready;

	always_comb begin
		logic signed [41:0] sum;
		logic signed [24:0] sh;
		for (int ch = 0; ch < 2; ch++) begin
			sum = prod_q[ch] + 42'sd65536;
			sh  = sum[41:17];
			if (sh > 25'sd32767) begin
				res_w[ch] = 16'sh7FFF;
			end else if (sh < -25'sd32768) begin
				res_w[ch] = -16'sh8000;
			end else begin
				res_w[ch] = sh[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_rate_q   <= csres_pkg::RESET_RATE;
			out_rate_q  <= csres_pkg::RESET_RATE;
			frames_q    <= '0;
			idx_q       <= '0;
			rem_q       <= '0;
			last_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				if (cfg_index == csres_pkg::REG_INPUT_RATE) begin
					in_rate_q <= cfg_data;
				end else begin
					out_rate_q <= cfg_data;
				end
				frames_q <= '0;
				idx_q    <= '0;
				rem_q    <= '0;
			end
			case (ctl.op)
				csres_pkg::OP_ACCEPT: begin
					frames_q <= fr_new;
					last_q   <= block_end || (fr_new >= FW'(MAX_BLOCK_FRAMES));
					cnt_q    <= '0;
				end
				csres_pkg::OP_PASS: begin
					out_valid_q <= 1'b1;
					if (last_q) begin
						frames_q <= '0;
						idx_q    <= '0;
						rem_q    <= '0;
					end
				end
				csres_pkg::OP_END: begin
					if (last_q) begin
						frames_q <= '0;
						idx_q    <= '0;
						rem_q    <= '0;
					end
				end
				csres_pkg::OP_COMMIT: begin
					idx_q <= idx_q + IW'(div_q_q);
					rem_q <= div_r_q[RW-1:0];
					cnt_q <= cnt_q + 1'b1;
				end
				csres_pkg::OP_EMIT: begin
					out_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			csres_pkg::OP_ACCEPT: begin
				if (frames_q == '0) begin
					for (int k = 0; k < 4; k++) begin
						win_q[0][k] <= left_in;
						win_q[1][k] <= right_in;
					end
				end else begin
					for (int k = 0; k < 3; k++) begin
						win_q[0][k] <= win_q[0][k+1];
						win_q[1][k] <= win_q[1][k+1];
					end
					win_q[0][3] <= left_in;
					win_q[1][3] <= right_in;
				end
			end
			csres_pkg::OP_PASS: begin
				left_q     <= win_q[0][3];
				right_q    <= win_q[1][3];
				run_last_q <= 1'b1;
			end
			csres_pkg::OP_DIV_T_INIT: begin
				div_r_q <= DW'(rem_q);
				div_a_q <= '0;
				div_q_q <= '0;
			end
			csres_pkg::OP_DIV_STEP: begin
				div_r_q <= r_nx;
				div_a_q <= {div_a_q[DW-2:0], 1'b0};
				div_q_q <= {div_q_q[DW-2:0], ge};
			end
			csres_pkg::OP_INTERP: begin
				for (int ch = 0; ch < 2; ch++) begin
					logic signed [19:0] p [4];
					for (int k = 0; k < 4; k++) begin
						p[k] = 20'(win_q[ch][((32'(d_w) + k) > 3) ? 3 : (32'(d_w) + k)]);
					end
					unique case (ctl.step)
						csres_pkg::STEP_W'(0): begin
							a_q[ch]  <= -p[0] + 20'sd3 * p[1] - 20'sd3 * p[2] + p[3];
							b_q[ch]  <= 21'(20'sd2 * p[0] - 20'sd5 * p[1]
								+ 20'sd4 * p[2] - p[3]);
							c_q[ch]  <= 18'(p[2] - p[0]);
							p1_q[ch] <= p[1][15:0];
						end
						csres_pkg::STEP_W'(1): begin
							prod_q[ch] <= 42'(a_q[ch]) * 42'(t_s);
						end
						csres_pkg::STEP_W'(2): begin
							h_q[ch] <= 24'(prod_q[ch] >>> 16) + 24'(b_q[ch]);
						end
						csres_pkg::STEP_W'(3): begin
							prod_q[ch] <= 42'(h_q[ch]) * 42'(t_s);
						end
						csres_pkg::STEP_W'(4): begin
							h_q[ch] <= 24'(prod_q[ch] >>> 16) + 24'(c_q[ch]);
						end
						default: begin
							prod_q[ch] <= 42'(h_q[ch]) * 42'(t_s)
								+ (42'(p1_q[ch]) <<< 17);
						end
					endcase
				end
				if (ctl.step == csres_pkg::STEP_W'(0)) begin
					t_q <= div_q_q[csres_pkg::T_W-1:0];
				end
				if (ctl.step == csres_pkg::STEP_W'(csres_pkg::IP_STEPS - 1)) begin
					div_r_q <= '0;
					div_a_q <= DW'(rem_q) + DW'(ri);
					div_q_q <= '0;
				end
			end
			csres_pkg::OP_EMIT: begin
				left_q     <= res_w[0];
				right_q    <= res_w[1];
				run_last_q <= sts.cnt_full || !sts.more;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_q;
	assign right_out = right_q;
	assign run_last  = run_last_q;
endmodule
`default_nettype wire

// File: hdl/cubic_stereo_resampler_core.sv
// With equal rates a frame is accepted in the idle state and passed through to the output
// word in the pass state, once the previous word has been taken. Otherwise each result runs
// through check, fraction divide, cubic evaluation, position divide, commit and load into
// the output word. A new word is taken only once all results of the previous one (up to 64
// results) have been emitted, or once it has been passed through with equal rates.
// Reset is asynchronous, active low; rates return to 48000 and the block to frame zero.
`default_nettype none
module cubic_stereo_resampler_core #(
	parameter int MAX_BLOCK_FRAMES   = csres_pkg::MAX_BLOCK_FRAMES,
	parameter int MAX_UPSAMPLE_RATIO = csres_pkg::MAX_UPSAMPLE_RATIO
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [0:0]                            cfg_index,
	input  wire logic [csres_pkg::RATE_W-1:0]          cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [csres_pkg::SAMPLE_W-1:0] left_in,
	input  wire logic signed [csres_pkg::SAMPLE_W-1:0] right_in,
	input  wire logic                                  block_end,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [csres_pkg::SAMPLE_W-1:0]      left_out,
	output logic signed [csres_pkg::SAMPLE_W-1:0]      right_out,
	output logic                                       run_last
);
	csres_pkg::ctl_t ctl;
	csres_pkg::sts_t sts;

	csres_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	csres_datapath #(
		.MAX_BLOCK_FRAMES   (MAX_BLOCK_FRAMES),
		.MAX_UPSAMPLE_RATIO (MAX_UPSAMPLE_RATIO)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.left_in   (left_in),
		.right_in  (right_in),
		.block_end (block_end),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.left_out  (left_out),
		.right_out (right_out),
		.run_last  (run_last),
		.ctl       (ctl),
		.sts       (sts)
	);
endmodule
`default_nettype wire

// File: hdl/csres_checker.sv
// Port-level checker for the cubic stereo resampler and its bind to the top level.
// Depends on csres_pkg.
`default_nettype none
module csres_checker (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  in_valid,
	input wire logic                                  in_ready,
	input wire logic                                  out_valid,
	input wire logic                                  out_ready,
	input wire logic signed [csres_pkg::SAMPLE_W-1:0] left_out,
	input wire logic signed [csres_pkg::SAMPLE_W-1:0] right_out,
	input wire logic                                  run_last
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_out)
			&& $stable(right_out) && $stable(run_last))
		else $error("Output word changed before it was taken.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Block ready again right after taking a word.");

	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("Output word appeared while the block was idle.");
endmodule

bind cubic_stereo_resampler_core csres_checker u_csres_checker (.*);
`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for cubic_stereo_resampler_core: drives stereo frames and rate
// writes, predicts every resampled word with a cycle-free model and checks them in order.
// Depends on csres_pkg and the core RTL.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic               last;
	} frame_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = '0;
	logic [csres_pkg::RATE_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] left_in = '0;
	logic signed [15:0] right_in = '0;
	logic block_end = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] left_out;
	logic signed [15:0] right_out;
	logic run_last;

	cubic_stereo_resampler_core dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state.
	logic [18:0] rate_in_reg = 19'd48000, rate_out_reg = 19'd48000;
	longint win_l[4], win_r[4];
	longint frames_seen, base_idx, pos_rem;
	frame_word_t expected_words[$];

	int errors = 0;
	int sent_frames = 0, checked_words = 0;
	int send_idle_pct = 0, recv_stall_pct = 0;
	bit hold_off = 1'b0;
	longint cycles = 0;

	function automatic longint floor_sh(longint x, int s);
		return x >>> s;
	endfunction

	function automatic logic signed [15:0] cubic_value(longint w[4], int d, longint t);
		longint p[4];
		longint a, b, c, h, v;
		for (int k = 0; k < 4; k++) p[k] = w[(d + k) > 3 ? 3 : d + k];
		a = -p[0] + 3 * p[1] - 3 * p[2] + p[3];
		b = 2 * p[0] - 5 * p[1] + 4 * p[2] - p[3];
		c = p[2] - p[0];
		h = floor_sh(a * t, 16) + b;
		h = floor_sh(h * t, 16) + c;
		v = floor_sh(h * t + p[1] * 131072 + 65536, 17);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	function automatic void restart_block();
		frames_seen = 0;
		base_idx = 0;
		pos_rem = 0;
	endfunction

	function automatic void predict_frame(logic signed [15:0] l, logic signed [15:0] r,
			logic fin);
		longint ri, ro, n, acc, t;
		int cnt, d;
		bit last;
		frame_word_t w;
		ri = (rate_in_reg == 0) ? 1 : rate_in_reg;
		ro = (rate_out_reg == 0) ? 1 : rate_out_reg;
		if (ro > ri * csres_pkg::MAX_UPSAMPLE_RATIO) ro = ri * csres_pkg::MAX_UPSAMPLE_RATIO;
		if (frames_seen == 0) begin
			for (int k = 0; k < 4; k++) begin
				win_l[k] = l;
				win_r[k] = r;
			end
		end else begin
			for (int k = 0; k < 3; k++) begin
				win_l[k] = win_l[k + 1];
				win_r[k] = win_r[k + 1];
			end
			win_l[3] = l;
			win_r[3] = r;
		end
		frames_seen++;
		n = frames_seen - 1;
		last = fin || frames_seen >= csres_pkg::MAX_BLOCK_FRAMES;
		if (ri == ro) begin
			w.left = l;
			w.right = r;
			w.last = 1'b1;
			expected_words.push_back(w);
			if (last) restart_block();
			return;
		end
		cnt = 0;
		while (cnt < csres_pkg::RESULT_LIMIT) begin
			if (last ? base_idx > n : base_idx + 2 > n) break;
			d = (base_idx + 2 >= n) ? int'(base_idx + 2 - n) : 0;
			t = (pos_rem << 16) / ro;
			w.left = cubic_value(win_l, d, t);
			w.right = cubic_value(win_r, d, t);
			w.last = 1'b0;
			expected_words.push_back(w);
			cnt++;
			acc = pos_rem + ri;
			base_idx = base_idx + acc / ro;
			pos_rem = acc % ro;
		end
		if (cnt > 0) expected_words[expected_words.size() - 1].last = 1'b1;
		if (last) restart_block();
	endfunction

	task automatic send_frame(logic signed [15:0] l, logic signed [15:0] r, logic fin);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		left_in <= l;
		right_in <= r;
		block_end <= fin;
		predict_frame(l, r, fin);
		sent_frames++;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_rate(csres_pkg::reg_idx_t idx, logic [18:0] val);
		drain_and_settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == csres_pkg::REG_INPUT_RATE) rate_in_reg = val;
		else rate_out_reg = val;
		restart_block();
	endtask

	task automatic set_rates(logic [18:0] ri, logic [18:0] ro);
		write_rate(csres_pkg::REG_INPUT_RATE, ri);
		write_rate(csres_pkg::REG_OUTPUT_RATE, ro);
	endtask

	task automatic send_block(int len, bit extreme);
		logic signed [15:0] l, r;
		for (int k = 0; k < len; k++) begin
			l = extreme ? ($urandom_range(1, 0) ? 16'sh7fff : 16'sh8000) : 16'($urandom);
			r = extreme ? ($urandom_range(1, 0) ? 16'sh7fff : 16'sh8000) : 16'($urandom);
			send_frame(l, r, k == len - 1);
		end
	endtask

	task automatic test_directed();
		send_frame(16'sh7fff, 16'sh8000, 1'b0);
		send_frame(16'sh8000, 16'sh7fff, 1'b0);
		send_frame(16'sh0000, 16'shffff, 1'b1);
		set_rates(19'd48000, 19'd44100);
		send_block(6, 1'b1);
		set_rates(19'd1, 19'd16);
		send_block(3, 1'b1);
		send_frame(16'sh1234, 16'sh4321, 1'b1);
		set_rates(19'd0, 19'h7ffff);
		send_block(2, 1'b0);
		set_rates(19'h7ffff, 19'd0);
		send_block(5, 1'b0);
		set_rates(19'd44100, 19'd96000);
		send_frame(16'sh0100, 16'sh0200, 1'b0);
		send_frame(16'sh0300, 16'sh0400, 1'b0);
	endtask

	task automatic test_random(int count);
		int len;
		logic [18:0] ri, ro;
		while (count > 0) begin
			case ($urandom_range(4, 0))
				0: begin ri = 19'd48000; ro = 19'd48000; end
				1: begin
					ri = 19'($urandom_range(384000, 8000));
					ro = 19'($urandom_range(384000, 8000));
				end
				2: begin
					ri = 19'($urandom_range(16, 1));
					ro = 19'($urandom_range(64, 1));
				end
				3: begin ri = 19'($urandom); ro = 19'($urandom); end
				default: begin ri = 19'd44100; ro = 19'd48000; end
			endcase
			set_rates(ri, ro);
			len = $urandom_range(12, 1);
			send_block(len, $urandom_range(9, 0) == 0);
			count -= len;
		end
	endtask

	task automatic test_backpressure();
		set_rates(19'd8000, 19'd48000);
		hold_off = 1'b1;
		send_block(10, 1'b0);
		hold_off = 1'b0;
	endtask

	always @(posedge clk) begin
		if (hold_off) out_ready <= 1'b0;
		else out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
	end

	// The long hold-off: the receiver stalls until this loop releases it, while the bench keeps offering frames.
	initial begin
		int stall_cycles;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				stall_cycles = 0;
				while (stall_cycles < 2000) begin
					@(posedge clk);
					stall_cycles++;
				end
				hold_off = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		frame_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected word L=%0d R=%0d last=%0b", $time, left_out,
					right_out, run_last);
			end else begin
				w = expected_words.pop_front();
				checked_words++;
				if (w.left !== left_out || w.right !== right_out || w.last !== run_last) begin
					errors++;
					$display("%0t: expected L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
						$time, w.left, w.right, w.last, left_out, right_out, run_last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 2500000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		restart_block();
		for (int k = 0; k < 4; k++) begin
			win_l[k] = 0;
			win_r[k] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(20);
		send_idle_pct = 86;
		test_random(20);
		send_idle_pct = 0;
		recv_stall_pct = 86;
		test_random(20);
		send_idle_pct = 9;
		recv_stall_pct = 9;
		test_random(20);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_backpressure();
		drain_and_settle();
		if (expected_words.size() != 0) errors++;
		$display("Sent %0d frames across many rate pairs and checked %0d output words.",
			sent_frames, checked_words);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
